// ===== rtl/core/dvf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential view factor package
// Shared constants, codes and packed types for the view factor pipeline.
// ----------------------------------------------------------------------------
package dvf_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int SLOT_W       = 10;
    localparam int PAIR_W       = 20;
    localparam int RCNT_W       = 11;

    // Pi in Q2.30.
    localparam logic [31:0] PI30 = 32'd3373259426;

    // Wide divider geometry: the numerator is normalized to 128 bits and the
    // denominator stays below 2^100 and at or above 2^91, so only the low
    // 37 quotient bits can be set.
    localparam int NUM_W = 128;
    localparam int DEN_W = 100;
    localparam int QUO_W = 37;

    localparam logic [1:0] REQ_EMITTER  = 2'd0;
    localparam logic [1:0] REQ_RECEIVER = 2'd1;
    localparam logic [1:0] REQ_COMPUTE  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_COINCIDENT = 2'd1;
    localparam logic [1:0] ST_SATURATED  = 2'd2;
    localparam logic [1:0] ST_RANGE      = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [SLOT_W-1:0] element_slot;
        logic signed [31:0] centroid_x;
        logic signed [31:0] centroid_y;
        logic signed [31:0] centroid_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [31:0]       element_area;
        logic [PAIR_W-1:0] pair_index;
    } in_item_t;

    typedef struct packed {
        logic [PAIR_W-1:0]  result_pair;
        logic signed [31:0] view_factor;
        logic [1:0]         status;
    } out_item_t;

    // Control that travels alongside each item through every stage.
    typedef struct packed {
        logic              valid;
        logic              res;
        logic [PAIR_W-1:0] pair;
        logic              done;
        logic [1:0]        status;
    } ctl_t;

    typedef struct packed {
        logic [2:0][31:0] c;
        logic [2:0][15:0] n;
    } emit_word_t;

    typedef struct packed {
        logic [2:0][31:0] c;
        logic [2:0][15:0] n;
        logic [31:0]      area;
    } recv_word_t;

    typedef struct packed {
        ctl_t       ctl;
        logic       neg;
        logic [8:0] t;
    } side_t;

endpackage

// ===== rtl/core/differential_view_factor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Differential view factor
// Element stores and a fully pipelined view factor datapath.
// ----------------------------------------------------------------------------
// The block takes one item per clock and keeps taking one per clock while
// the result side accepts. Load and compute items share one in-order
// pipeline of 70 stages: 20 stages split the pair index by receiver_count,
// one stage reads the element stores (loads write them at that same point,
// so every compute sees exactly the loads accepted before it), 11 stages
// form the dot products, normalize and multiply, 37 stages divide, and one
// stage saturates into the output register. A stalled output holds the
// whole pipeline. receiver_count may be written only while no item is in
// flight; its write is always accepted at once.
// ----------------------------------------------------------------------------
module differential_view_factor (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  dvf_pkg::in_item_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output dvf_pkg::out_item_t           m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dvf_pkg::RCNT_W-1:0]   cfg_data
);

    import dvf_pkg::*;

    typedef struct packed {
        logic              valid;
        in_item_t          item;
        logic [RCNT_W-1:0] rem;
        logic [PAIR_W-1:0] quo;
    } split_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [2:0]       neg;
        logic [2:0][32:0] u;
        logic [2:0][15:0] ne;
        logic [2:0][15:0] nr;
        logic [31:0]      area;
    } st_a_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [2:0]       neg;
        logic [2:0][32:0] u;
        logic [5:0]       k;
        logic [2:0][15:0] ne;
        logic [2:0][15:0] nr;
        logic [31:0]      area;
    } st_b_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [2:0][16:0] v;
        logic [2:0][15:0] m;
        logic [5:0]       k;
        logic [2:0][15:0] ne;
        logic [2:0][15:0] nr;
        logic [31:0]      area;
    } st_c_t;

    typedef struct packed {
        ctl_t             ctl;
        logic [2:0][32:0] pa;
        logic [2:0][32:0] pb;
        logic [2:0][31:0] sq;
        logic [5:0]       k;
        logic [31:0]      area;
    } st_d_t;

    typedef struct packed {
        ctl_t        ctl;
        logic [34:0] a;
        logic [34:0] b;
        logic [33:0] qq;
        logic [5:0]  k;
        logic [31:0] area;
    } st_e_t;

    typedef struct packed {
        ctl_t        ctl;
        logic        neg;
        logic [32:0] ua;
        logic [32:0] ub;
        logic [33:0] qq;
        logic [5:0]  k;
        logic [31:0] area;
    } st_f_t;

    typedef struct packed {
        ctl_t        ctl;
        logic        neg;
        logic [65:0] p1;
        logic [67:0] q2;
        logic [5:0]  k;
        logic [31:0] area;
    } st_g_t;

    typedef struct packed {
        ctl_t        ctl;
        logic        neg;
        logic [5:0]  k;
        logic [64:0] nlo;
        logic [64:0] nhi;
        logic [65:0] dlo;
        logic [65:0] dhi;
    } st_h_t;

    typedef struct packed {
        ctl_t             ctl;
        logic             neg;
        logic [5:0]       k;
        logic [97:0]      nv;
        logic [DEN_W-1:0] dv;
    } st_i_t;

    typedef struct packed {
        ctl_t             ctl;
        logic             neg;
        logic [5:0]       k;
        logic [97:0]      nv;
        logic [DEN_W-1:0] dv;
        logic [5:0]       blh;
        logic [5:0]       bll;
    } st_j_t;

    function automatic logic [5:0] bit_len(input logic [48:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 49; i++) begin
            if (v[i]) begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

    logic              pipe_en;
    logic [RCNT_W-1:0] rcount_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rcount_reg <= RCNT_W'(1);
        end else if (cfg_valid) begin
            rcount_reg <= cfg_data;
        end
    end

    // A stalled result freezes every stage, so nothing is lost or repeated.
    assign pipe_en = !(m_valid && !m_ready);
    assign s_ready = pipe_en;

    // ------------------------------------------------------------------
    // Pair split: one quotient bit per stage.
    // ------------------------------------------------------------------
    split_t sp_reg [PAIR_W];
    split_t sp_first_w;

    always_comb begin
        sp_first_w.valid = s_valid;
        sp_first_w.item  = s_data;
        sp_first_w.rem   = '0;
        sp_first_w.quo   = '0;
    end

    for (genvar j = 0; j < PAIR_W; j++) begin : g_split
        split_t            src_w;
        split_t            sp_next;
        logic [RCNT_W:0]   r2;
        logic [RCNT_W:0]   diff;

        if (j == 0) begin : g_first
            assign src_w = sp_first_w;
        end else begin : g_rest
            assign src_w = sp_reg[j-1];
        end

        always_comb begin
            r2      = {src_w.rem, src_w.item.pair_index[PAIR_W-1-j]};
            diff    = r2 - {1'b0, rcount_reg};
            sp_next = src_w;
            if (!diff[RCNT_W]) begin
                sp_next.rem = diff[RCNT_W-1:0];
                sp_next.quo = {src_w.quo[PAIR_W-2:0], 1'b1};
            end else begin
                sp_next.rem = r2[RCNT_W-1:0];
                sp_next.quo = {src_w.quo[PAIR_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sp_reg[j].valid <= 1'b0;
            end else if (pipe_en) begin
                sp_reg[j] <= sp_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Element stores: loads write and computes read at the same point.
    // ------------------------------------------------------------------
    split_t     sp_last;
    logic       slot_ok;
    logic       idx_bad;
    logic       em_we;
    logic       rv_we;
    emit_word_t em_wdata;
    recv_word_t rv_wdata;
    emit_word_t em_q;
    recv_word_t rv_q;
    ctl_t       rd_reg;
    ctl_t       rd_next;

    assign sp_last = sp_reg[PAIR_W-1];
    assign slot_ok = 32'(sp_last.item.element_slot) < 32'(MAX_ELEMENTS);
    assign idx_bad = (rcount_reg == '0)
                  || (32'(sp_last.quo) >= 32'(MAX_ELEMENTS))
                  || (32'(sp_last.rem) >= 32'(MAX_ELEMENTS));
    assign em_we = pipe_en && sp_last.valid && slot_ok
                && (sp_last.item.req_type == REQ_EMITTER);
    assign rv_we = pipe_en && sp_last.valid && slot_ok
                && (sp_last.item.req_type == REQ_RECEIVER);

    always_comb begin
        em_wdata.c    = {sp_last.item.centroid_z, sp_last.item.centroid_y,
                         sp_last.item.centroid_x};
        em_wdata.n    = {sp_last.item.normal_z, sp_last.item.normal_y,
                         sp_last.item.normal_x};
        rv_wdata.c    = em_wdata.c;
        rv_wdata.n    = em_wdata.n;
        rv_wdata.area = sp_last.item.element_area;
    end

    dvf_ram #(
        .WIDTH ($bits(emit_word_t)),
        .DEPTH (MAX_ELEMENTS)
    ) u_emit_ram (
        .aclk  (aclk),
        .we    (em_we),
        .waddr (ADDR_W'(sp_last.item.element_slot)),
        .wdata (em_wdata),
        .re    (pipe_en),
        .raddr (ADDR_W'(sp_last.quo)),
        .rdata (em_q)
    );

    dvf_ram #(
        .WIDTH ($bits(recv_word_t)),
        .DEPTH (MAX_ELEMENTS)
    ) u_recv_ram (
        .aclk  (aclk),
        .we    (rv_we),
        .waddr (ADDR_W'(sp_last.item.element_slot)),
        .wdata (rv_wdata),
        .re    (pipe_en),
        .raddr (ADDR_W'(sp_last.rem)),
        .rdata (rv_q)
    );

    always_comb begin
        rd_next.valid  = sp_last.valid;
        rd_next.res    = (sp_last.item.req_type == REQ_COMPUTE);
        rd_next.pair   = sp_last.item.pair_index;
        rd_next.done   = idx_bad;
        rd_next.status = idx_bad ? ST_RANGE : ST_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg.valid <= 1'b0;
        end else if (pipe_en) begin
            rd_reg <= rd_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: separation vector, sign and magnitude.
    // ------------------------------------------------------------------
    st_a_t a_reg, a_next;

    always_comb begin
        logic [32:0] d;
        a_next.ctl  = rd_reg;
        a_next.ne   = em_q.n;
        a_next.nr   = rv_q.n;
        a_next.area = rv_q.area;
        for (int i = 0; i < 3; i++) begin
            d = {em_q.c[i][31], em_q.c[i]} - {rv_q.c[i][31], rv_q.c[i]};
            a_next.neg[i] = d[32];
            a_next.u[i]   = d[32] ? (33'd0 - d) : d;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg.ctl.valid <= 1'b0;
        end else if (pipe_en) begin
            a_reg <= a_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: bit length of the largest component.
    // ------------------------------------------------------------------
    st_b_t b_reg, b_next;

    always_comb begin
        logic [32:0] any_bits;
        any_bits    = a_reg.u[0] | a_reg.u[1] | a_reg.u[2];
        b_next.ctl  = a_reg.ctl;
        b_next.neg  = a_reg.neg;
        b_next.u    = a_reg.u;
        b_next.k    = bit_len(49'(any_bits));
        b_next.ne   = a_reg.ne;
        b_next.nr   = a_reg.nr;
        b_next.area = a_reg.area;
        if (any_bits == '0 && !a_reg.ctl.done) begin
            b_next.ctl.done   = 1'b1;
            b_next.ctl.status = ST_COINCIDENT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg.ctl.valid <= 1'b0;
        end else if (pipe_en) begin
            b_reg <= b_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: scale every component to a 16-bit mantissa.
    // ------------------------------------------------------------------
    st_c_t c_reg, c_next;

    always_comb begin
        logic [32:0] sh;
        c_next.ctl  = b_reg.ctl;
        c_next.k    = b_reg.k;
        c_next.ne   = b_reg.ne;
        c_next.nr   = b_reg.nr;
        c_next.area = b_reg.area;
        for (int i = 0; i < 3; i++) begin
            if (b_reg.k > 6'd16) begin
                sh = b_reg.u[i] >> (b_reg.k - 6'd16);
            end else begin
                sh = b_reg.u[i] << (6'd16 - b_reg.k);
            end
            c_next.m[i] = sh[15:0];
            c_next.v[i] = b_reg.neg[i] ? (17'd0 - {1'b0, sh[15:0]}) : {1'b0, sh[15:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_reg.ctl.valid <= 1'b0;
        end else if (pipe_en) begin
            c_reg <= c_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: component products.
    // ------------------------------------------------------------------
    st_d_t d_reg, d_next;

    always_comb begin
        d_next.ctl  = c_reg.ctl;
        d_next.k    = c_reg.k;
        d_next.area = c_reg.area;
        for (int i = 0; i < 3; i++) begin
            d_next.pa[i] = $signed(c_reg.ne[i]) * $signed(c_reg.v[i]);
            d_next.pb[i] = $signed(c_reg.nr[i]) * $signed(c_reg.v[i]);
            d_next.sq[i] = c_reg.m[i] * c_reg.m[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_reg.ctl.valid <= 1'b0;
        end else if (pipe_en) begin
            d_reg <= d_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage E: dot products and squared length.
    // ------------------------------------------------------------------
    st_e_t e_reg, e_next;

    always_comb begin
        e_next.ctl  = d_reg.ctl;
        e_next.k    = d_reg.k;
        e_next.area = d_reg.area;
        e_next.a    = {{2{d_reg.pa[0][32]}}, d_reg.pa[0]}
                    + {{2{d_reg.pa[1][32]}}, d_reg.pa[1]}
                    + {{2{d_reg.pa[2][32]}}, d_reg.pa[2]};
        e_next.b    = {{2{d_reg.pb[0][32]}}, d_reg.pb[0]}
                    + {{2{d_reg.pb[1][32]}}, d_reg.pb[1]}
                    + {{2{d_reg.pb[2][32]}}, d_reg.pb[2]};
        e_next.qq   = 34'(d_reg.sq[0]) + 34'(d_reg.sq[1]) + 34'(d_reg.sq[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_reg.ctl.valid <= 1'b0;
        end else if (pipe_en) begin
            e_reg <= e_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: magnitudes, result sign and the zero factor case.
    // ------------------------------------------------------------------
    st_f_t f_reg, f_next;

    always_comb begin
        f_next.ctl  = e_reg.ctl;
        f_next.k    = e_reg.k;
        f_next.area = e_reg.area;
        f_next.qq   = e_reg.qq;
        f_next.neg  = (e_reg.a[34] == e_reg.b[34]);
        f_next.ua   = e_reg.a[34] ? 33'(35'd0 - e_reg.a) : e_reg.a[32:0];
        f_next.ub   = e_reg.b[34] ? 33'(35'd0 - e_reg.b) : e_reg.b[32:0];
        if ((e_reg.a == '0 || e_reg.b == '0 || e_reg.area == '0) && !e_reg.ctl.done) begin
            f_next.ctl.done   = 1'b1;
            f_next.ctl.status = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_reg.ctl.valid <= 1'b0;
        end else if (pipe_en) begin
            f_reg <= f_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: |a||b| and q^2.
    // ------------------------------------------------------------------
    st_g_t g_reg, g_next;

    always_comb begin
        g_next.ctl  = f_reg.ctl;
        g_next.neg  = f_reg.neg;
        g_next.k    = f_reg.k;
        g_next.area = f_reg.area;
        g_next.p1   = f_reg.ua * f_reg.ub;
        g_next.q2   = f_reg.qq * f_reg.qq;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_reg.ctl.valid <= 1'b0;
        end else if (pipe_en) begin
            g_reg <= g_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage H: partial products for the numerator and the denominator.
    // ------------------------------------------------------------------
    st_h_t h_reg, h_next;

    always_comb begin
        h_next.ctl = g_reg.ctl;
        h_next.neg = g_reg.neg;
        h_next.k   = g_reg.k;
        h_next.nlo = g_reg.p1[32:0] * g_reg.area;
        h_next.nhi = g_reg.p1[65:33] * g_reg.area;
        h_next.dlo = g_reg.q2[33:0] * PI30;
        h_next.dhi = g_reg.q2[67:34] * PI30;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_reg.ctl.valid <= 1'b0;
        end else if (pipe_en) begin
            h_reg <= h_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage I: combine partial products.
    // ------------------------------------------------------------------
    st_i_t i_reg, i_next;

    always_comb begin
        i_next.ctl = h_reg.ctl;
        i_next.neg = h_reg.neg;
        i_next.k   = h_reg.k;
        i_next.nv  = 98'(h_reg.nlo) + {h_reg.nhi, 33'd0};
        i_next.dv  = DEN_W'(h_reg.dlo) + {h_reg.dhi, 34'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg.ctl.valid <= 1'b0;
        end else if (pipe_en) begin
            i_reg <= i_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage J: bit length of each numerator half.
    // ------------------------------------------------------------------
    st_j_t j_reg, j_next;

    always_comb begin
        j_next.ctl = i_reg.ctl;
        j_next.neg = i_reg.neg;
        j_next.k   = i_reg.k;
        j_next.nv  = i_reg.nv;
        j_next.dv  = i_reg.dv;
        j_next.blh = bit_len(i_reg.nv[97:49]);
        j_next.bll = bit_len(i_reg.nv[48:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            j_reg.ctl.valid <= 1'b0;
        end else if (pipe_en) begin
            j_reg <= j_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage K: normalize the numerator and form the output exponent.
    // ------------------------------------------------------------------
    logic [6:0]       blen;
    logic [7:0]       lsh;
    logic [NUM_W-1:0] nsh_reg;
    logic [DEN_W-1:0] den_reg;
    side_t            side_reg;
    side_t            side_next;

    assign blen = (j_reg.blh != '0) ? (7'(j_reg.blh) + 7'd49) : 7'(j_reg.bll);
    assign lsh  = 8'd128 - {1'b0, blen};

    always_comb begin
        side_next.ctl = j_reg.ctl;
        side_next.neg = j_reg.neg;
        // t = 2e + 42 - L with e = 16 - k.
        side_next.t   = 9'd74 - {2'b0, j_reg.k, 1'b0} - {1'b0, lsh};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg.ctl.valid <= 1'b0;
        end else if (pipe_en) begin
            side_reg <= side_next;
            nsh_reg  <= NUM_W'(j_reg.nv) << lsh;
            den_reg  <= j_reg.dv;
        end
    end

    // ------------------------------------------------------------------
    // Division.
    // ------------------------------------------------------------------
    logic [QUO_W-1:0] div_quo;
    side_t            div_side;

    dvf_wdiv u_wdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .num      (nsh_reg),
        .den      (den_reg),
        .side_in  (side_reg),
        .quo      (div_quo),
        .side_out (div_side)
    );

    // ------------------------------------------------------------------
    // Output stage: exponent shift, saturation and sign.
    // ------------------------------------------------------------------
    logic      out_valid_reg;
    out_item_t out_reg;
    out_item_t out_next;

    always_comb begin
        logic [31:0] lim;
        logic [68:0] val;
        logic [7:0]  tn;
        logic        over;
        logic [31:0] mag;
        lim  = div_side.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        tn   = 8'(9'd0 - div_side.t);
        if (!div_side.t[8]) begin
            val = (div_side.t[7:5] == 3'd0) ? (69'(div_quo) << div_side.t[4:0]) : '0;
        end else begin
            val = 69'(div_quo >> tn);
        end
        over = (!div_side.t[8] && div_side.t[7:5] != 3'd0) || (val > 69'(lim));
        mag  = over ? lim : val[31:0];
        out_next.result_pair = div_side.ctl.pair;
        if (div_side.ctl.done) begin
            out_next.view_factor = '0;
            out_next.status      = div_side.ctl.status;
        end else begin
            out_next.view_factor = div_side.neg ? (32'd0 - mag) : mag;
            out_next.status      = over ? ST_SATURATED : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= div_side.ctl.valid && div_side.ctl.res;
            out_reg       <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_RANGE || m_data.status == ST_COINCIDENT)
        |-> m_data.view_factor == '0)
        else $error("error status carries a nonzero view factor");

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_SATURATED
        |-> (m_data.view_factor == 32'sh7FFF_FFFF || m_data.view_factor == 32'sh8000_0000))
        else $error("saturated result is not at a bound");

    a_no_write_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |-> !em_we && !rv_we)
        else $error("element store written while the pipeline is stalled");

endmodule

// ===== rtl/core/dvf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module dvf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== rtl/core/dvf_wdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wide pipelined divider
// Restoring division, one quotient bit per stage, side data carried along.
// ----------------------------------------------------------------------------
module dvf_wdiv (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic [dvf_pkg::NUM_W-1:0]   num,
    input  logic [dvf_pkg::DEN_W-1:0]   den,
    input  dvf_pkg::side_t              side_in,
    output logic [dvf_pkg::QUO_W-1:0]   quo,
    output dvf_pkg::side_t              side_out
);

    import dvf_pkg::*;

    typedef struct packed {
        side_t            side;
        logic [DEN_W-1:0] den;
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
    } dstage_t;

    dstage_t st_reg [QUO_W];
    dstage_t first_w;

    // The upper numerator bits are already known to lie below the divisor.
    always_comb begin
        first_w.side = side_in;
        first_w.den  = den;
        first_w.rem  = DEN_W'(num[NUM_W-1:QUO_W]);
        first_w.low  = num[QUO_W-1:0];
        first_w.quo  = '0;
    end

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        dstage_t        src_w;
        dstage_t        stage_next;
        logic [DEN_W:0] r2;
        logic [DEN_W:0] diff;

        if (i == 0) begin : g_first
            assign src_w = first_w;
        end else begin : g_rest
            assign src_w = st_reg[i-1];
        end

        always_comb begin
            r2         = {src_w.rem, src_w.low[QUO_W-1]};
            diff       = r2 - {1'b0, src_w.den};
            stage_next = src_w;
            stage_next.low = {src_w.low[QUO_W-2:0], 1'b0};
            if (!diff[DEN_W]) begin
                stage_next.rem = diff[DEN_W-1:0];
                stage_next.quo = {src_w.quo[QUO_W-2:0], 1'b1};
            end else begin
                stage_next.rem = r2[DEN_W-1:0];
                stage_next.quo = {src_w.quo[QUO_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[i].side.ctl.valid <= 1'b0;
            end else if (en) begin
                st_reg[i] <= stage_next;
            end
        end
    end

    assign quo      = st_reg[QUO_W-1].quo;
    assign side_out = st_reg[QUO_W-1].side;

endmodule
